/* src/apt_pkg.sv */
// Shared types and constants for the speech playback turn controller.
`timescale 1ns / 1ps

package apt_pkg;

    localparam int LEVEL_W = 20;
    localparam int GEN_W   = 16;
    localparam int KIND_W  = 4;
    localparam int STATE_W = 4;
    localparam int COUNT_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [LEVEL_W-1:0] PREBUFFER_RESET = LEVEL_W'(128 * 1024);
    localparam logic [LEVEL_W-1:0] WARNING_RESET   = LEVEL_W'(64 * 1024);
    localparam logic [LEVEL_W-1:0] CRITICAL_RESET  = LEVEL_W'(32 * 1024);
    localparam logic [GEN_W-1:0]   START_GEN_RESET = '0;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_BEGIN       = 4'd0;
    localparam logic [KIND_W-1:0] KIND_AUDIO       = 4'd1;
    localparam logic [KIND_W-1:0] KIND_TURN_DONE   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_PLAY_START  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_LOW         = 4'd4;
    localparam logic [KIND_W-1:0] KIND_DRAINED     = 4'd5;
    localparam logic [KIND_W-1:0] KIND_I2S_DRAINED = 4'd6;
    localparam logic [KIND_W-1:0] KIND_INTERRUPT   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_GEN_CHANGE  = 4'd8;
    localparam logic [KIND_W-1:0] KIND_ERROR       = 4'd9;
    localparam logic [KIND_W-1:0] KIND_SYNC        = 4'd10;
    localparam logic [KIND_W-1:0] KIND_LEVEL       = 4'd11;
    localparam logic [KIND_W-1:0] KIND_UNDERRUN    = 4'd12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PREBUFFER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARNING   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_GEN = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [GEN_W-1:0]   generation;
        logic [LEVEL_W-1:0] fill_bytes;
    } apt_item_t;

    typedef struct packed {
        logic [STATE_W-1:0] engine_state;
        logic               turn_active;
        logic               complete_pending;
        logic               model_done;
        logic               playback_begun;
        logic               playback_emptied;
        logic               turn_finished;
        logic [COUNT_W-1:0] underruns;
        logic [GEN_W-1:0]   turn_generation;
    } apt_result_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] prebuffer_level;
        logic [LEVEL_W-1:0] warning_level;
        logic [LEVEL_W-1:0] critical_level;
        logic               gen_load;
        logic [GEN_W-1:0]   gen_value;
    } apt_cfg_t;

endpackage

/* src/apt_cfg.sv */
// Configuration registers for the playback turn controller.
`timescale 1ns / 1ps

module apt_cfg
    import apt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output apt_cfg_t              cfg
);

    logic [LEVEL_W-1:0] prebuffer_reg;
    logic [LEVEL_W-1:0] warning_reg;
    logic [LEVEL_W-1:0] critical_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prebuffer_reg <= PREBUFFER_RESET;
            warning_reg   <= WARNING_RESET;
            critical_reg  <= CRITICAL_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PREBUFFER: prebuffer_reg <= cfg_data[LEVEL_W-1:0];
                CFG_WARNING:   warning_reg   <= cfg_data[LEVEL_W-1:0];
                CFG_CRITICAL:  critical_reg  <= cfg_data[LEVEL_W-1:0];
                default:       ;
            endcase
        end
    end

    // Start generation lives in the core as its generation registers
    assign cfg.prebuffer_level = prebuffer_reg;
    assign cfg.warning_level   = warning_reg;
    assign cfg.critical_level  = critical_reg;
    assign cfg.gen_load        = cfg_valid && (cfg_index == CFG_START_GEN);
    assign cfg.gen_value       = cfg_data[GEN_W-1:0];

endmodule

/* src/apt_core.sv */
// Turn state machine: state registers and the next-state logic for one request.
`timescale 1ns / 1ps

module apt_core
    import apt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  apt_cfg_t    cfg,
    input  logic        step,
    input  apt_item_t   item,
    output apt_result_t result
);

    typedef enum logic [STATE_W-1:0] {
        ST_IDLE        = 4'd0,
        ST_LISTEN      = 4'd1,
        ST_THINK       = 4'd2,
        ST_BUFFER      = 4'd3,
        ST_PLAY        = 4'd4,
        ST_PLAY_LOW    = 4'd5,
        ST_DRAIN       = 4'd6,
        ST_COMPLETE    = 4'd7,
        ST_INTERRUPTED = 4'd8,
        ST_ERROR       = 4'd9
    } state_t;

    state_t             state_reg, state_next;
    logic [GEN_W-1:0]   turn_gen_reg, turn_gen_next;
    logic [GEN_W-1:0]   last_gen_reg, last_gen_next;
    logic               model_done_reg, model_done_next;
    logic               play_begun_reg, play_begun_next;
    logic               emptied_reg, emptied_next;
    logic               active_reg, active_next;
    logic               pending_reg, pending_next;
    logic [COUNT_W-1:0] underrun_reg, underrun_next;
    logic               finished;

    always_comb
    begin
        state_next      = state_reg;
        turn_gen_next   = turn_gen_reg;
        last_gen_next   = last_gen_reg;
        model_done_next = model_done_reg;
        play_begun_next = play_begun_reg;
        emptied_next    = emptied_reg;
        active_next     = active_reg;
        pending_next    = pending_reg;
        underrun_next   = underrun_reg;
        finished        = 1'b0;

        // A turn event from another connection drops the turn first
        if ((item.kind <= KIND_ERROR) && (item.generation != '0)
            && (item.generation != turn_gen_reg))
        begin
            model_done_next = 1'b0;
            play_begun_next = 1'b0;
            emptied_next    = 1'b0;
            underrun_next   = '0;
            turn_gen_next   = item.generation;
            last_gen_next   = item.generation;
            active_next     = 1'b0;
            pending_next    = 1'b0;
            state_next      = ST_IDLE;
        end

        unique case (item.kind) inside
            KIND_BEGIN, KIND_AUDIO:
            begin
                active_next = 1'b1;
                if (item.kind == KIND_BEGIN)
                    pending_next = 1'b0;
                if (state_next == ST_IDLE || state_next == ST_LISTEN
                    || state_next == ST_THINK)
                    state_next = ST_BUFFER;
            end
            KIND_TURN_DONE:
            begin
                model_done_next = 1'b1;
                pending_next    = 1'b1;
                if (state_next == ST_PLAY || state_next == ST_PLAY_LOW
                    || state_next == ST_BUFFER)
                    state_next = ST_DRAIN;
            end
            KIND_PLAY_START:
            begin
                play_begun_next = 1'b1;
                state_next      = ST_PLAY;
            end
            KIND_LOW:
            begin
                if (state_next == ST_PLAY)
                    state_next = ST_PLAY_LOW;
            end
            KIND_DRAINED:
                emptied_next = 1'b1;
            KIND_I2S_DRAINED:
            begin
                emptied_next = 1'b1;
                if (model_done_next)
                begin
                    pending_next = 1'b0;
                    active_next  = 1'b0;
                    state_next   = ST_IDLE;
                    finished     = 1'b1;
                end
            end
            KIND_INTERRUPT:
            begin
                pending_next    = 1'b0;
                active_next     = 1'b0;
                state_next      = ST_INTERRUPTED;
                model_done_next = 1'b0;
                play_begun_next = 1'b0;
                emptied_next    = 1'b0;
                underrun_next   = '0;
            end
            KIND_GEN_CHANGE:
            begin
                model_done_next = 1'b0;
                play_begun_next = 1'b0;
                emptied_next    = 1'b0;
                underrun_next   = '0;
                turn_gen_next   = item.generation;
                last_gen_next   = item.generation;
                active_next     = 1'b0;
                pending_next    = 1'b0;
                state_next      = ST_IDLE;
            end
            KIND_ERROR:
                state_next = ST_ERROR;
            KIND_SYNC:
            begin
                if (item.generation != last_gen_reg)
                begin
                    model_done_next = 1'b0;
                    play_begun_next = 1'b0;
                    emptied_next    = 1'b0;
                    underrun_next   = '0;
                    turn_gen_next   = item.generation;
                    last_gen_next   = item.generation;
                    active_next     = 1'b0;
                    pending_next    = 1'b0;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    turn_gen_next = item.generation;
                    if (pending_reg || model_done_reg)
                    begin
                        model_done_next = 1'b1;
                        if (item.fill_bytes != '0)
                            state_next = ST_DRAIN;
                        else if (state_reg != ST_COMPLETE && state_reg != ST_IDLE)
                        begin
                            state_next = ST_IDLE;
                            finished   = 1'b1;
                        end
                    end
                    else if (active_reg)
                    begin
                        // Prebuffer threshold, then warning/critical hysteresis
                        if (item.fill_bytes >= cfg.prebuffer_level
                            && state_reg != ST_PLAY && state_reg != ST_PLAY_LOW)
                            state_next = ST_PLAY;
                        else if (item.fill_bytes != '0 && state_reg == ST_IDLE)
                            state_next = ST_BUFFER;

                        if (state_next == ST_PLAY
                            && item.fill_bytes < cfg.critical_level)
                            state_next = ST_PLAY_LOW;
                        else if (state_next == ST_PLAY_LOW
                            && item.fill_bytes >= cfg.warning_level)
                            state_next = ST_PLAY;
                    end
                end
            end
            KIND_UNDERRUN:
            begin
                if (underrun_reg != '1)
                    underrun_next = underrun_reg + COUNT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            turn_gen_reg   <= START_GEN_RESET;
            last_gen_reg   <= START_GEN_RESET;
            model_done_reg <= 1'b0;
            play_begun_reg <= 1'b0;
            emptied_reg    <= 1'b0;
            active_reg     <= 1'b0;
            pending_reg    <= 1'b0;
            underrun_reg   <= '0;
        end
        else if (cfg.gen_load)
        begin
            // Fresh start: keep engine state and active/pending flags
            turn_gen_reg   <= cfg.gen_value;
            last_gen_reg   <= cfg.gen_value;
            model_done_reg <= 1'b0;
            play_begun_reg <= 1'b0;
            emptied_reg    <= 1'b0;
            underrun_reg   <= '0;
        end
        else if (step)
        begin
            state_reg      <= state_next;
            turn_gen_reg   <= turn_gen_next;
            last_gen_reg   <= last_gen_next;
            model_done_reg <= model_done_next;
            play_begun_reg <= play_begun_next;
            emptied_reg    <= emptied_next;
            active_reg     <= active_next;
            pending_reg    <= pending_next;
            underrun_reg   <= underrun_next;
        end
    end

    assign result.engine_state     = STATE_W'(state_next);
    assign result.turn_active      = active_next;
    assign result.complete_pending = pending_next;
    assign result.model_done       = model_done_next;
    assign result.playback_begun   = play_begun_next;
    assign result.playback_emptied = emptied_next;
    assign result.turn_finished    = finished;
    assign result.underruns        = underrun_next;
    assign result.turn_generation  = turn_gen_next;

endmodule

/* src/audio_playback_turn_fsm_unit.sv */
// Speech playback turn controller: input register, turn state machine, result register.
// A request is held in the input register, and its result is registered in the result register that drives out_result.
// Throughput: one request per cycle; the input register holds a request only while
// the result register is full and stalled.
// Reset (rst_n, asynchronous, active low): engine idle, flags and underrun count clear,
// generations at START_GEN_RESET, levels at their defaults, both channels empty.
`timescale 1ns / 1ps

module audio_playback_turn_fsm_unit
    import apt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  apt_item_t             in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output apt_result_t           out_result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic        item_valid_reg;
    apt_item_t   item_reg;
    logic        out_valid_reg;
    apt_result_t out_result_reg;
    apt_cfg_t    cfg;
    apt_result_t result;
    logic        advance;

    apt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    apt_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (advance),
        .item   (item_reg),
        .result (result)
    );

    // Move the held request into the result register when that slot frees up
    assign advance  = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                item_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            item_reg <= in_item;
        if (advance)
            out_result_reg <= result;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule
